FILE: hw/rtl/heartbeat_liveness_monitor_defines.svh
// assertion macros shared by the liveness monitor rtl
// no dependencies; included by files that carry assertions
`ifndef HEARTBEAT_LIVENESS_MONITOR_DEFINES_SVH
`define HEARTBEAT_LIVENESS_MONITOR_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define HLM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define HLM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

// condition never seen
`define HLM_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("%m: forbidden condition seen");

`endif

FILE: hw/rtl/hlm_pkg.sv
// shared types and constants for the heartbeat liveness monitor
// no dependencies
package hlm_pkg;

   localparam int NUM_SESSIONS = 16;
   localparam int ADDR_W = (NUM_SESSIONS > 1) ? $clog2(NUM_SESSIONS) : 1;

   localparam int TIME_W = 32;
   localparam int SEQ_W = 32;
   localparam int MISS_W = 9;
   localparam int ID_W = 4;
   localparam int EV_W = 3;
   localparam int REQ_W = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int IVL_W = 16;
   localparam int TMO_W = 16;
   localparam int RETRY_W = 8;

   localparam logic [MISS_W-1:0] MISS_MAX = '1;

   localparam logic [IVL_W-1:0] PING_INTERVAL_RST = IVL_W'(5);
   localparam logic [TMO_W-1:0] PONG_TIMEOUT_RST = TMO_W'(3);
   localparam logic [RETRY_W-1:0] MAX_RETRIES_RST = RETRY_W'(3);

   typedef enum logic [REQ_W-1:0] {
      REQ_TICK = 2'd0,
      REQ_PONG = 2'd1,
      REQ_ACTIVITY = 2'd2,
      REQ_NONE = 2'd3
   } req_code_type;

   typedef enum logic [EV_W-1:0] {
      EV_PING = 3'd0,
      EV_INACTIVE = 3'd1,
      EV_PONG = 3'd2,
      EV_UPDATED = 3'd3,
      EV_SCAN_DONE = 3'd4
   } event_code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PING_INTERVAL = 2'd0,
      CSR_PONG_TIMEOUT = 2'd1,
      CSR_MAX_RETRIES = 2'd2
   } csr_code_type;

   // one session record as held in the table memory
   typedef struct packed {
      logic active;
      logic awaiting;
      logic [MISS_W-1:0] missed;
      logic [TIME_W-1:0] last_act;
      logic [TIME_W-1:0] ping_sent;
      logic [SEQ_W-1:0] peer_seq;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

FILE: hw/rtl/hlm_ram.sv
// generic single-write, single-read synchronous ram, registered read
// no dependencies
module hlm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/heartbeat_liveness_monitor.sv
// heartbeat liveness monitor top level: sequencer over the session table
// depends on hlm_pkg, hlm_ram and heartbeat_liveness_monitor_defines.svh
//
//   channel   ports                                   handshake
//   -------   -------------------------------------   -------------------------
//   request   req_type, req_session_index,            start while busy is low
//             req_activity_seq
//   response  rsp_event_res, rsp_session_id,          rsp_valid strobe, 1 cycle
//             rsp_ping_seq, rsp_is_last
//   csr       csr_index, csr_wdata                    csr_valid and csr_ready
//
// a tick keeps busy high through the scan and the done state: the single table read
// port visits one session per cycle, then the done state emits scan done
// a pong or activity request keeps busy high in the access state (read, modify, write)
// responses leave registered, in the cycle after the entry is processed; no back pressure
// synchronous reset clears time, the per-entry valid bits and the control registers;
// an entry never written reads as all zero, so no clearing pass is needed
// requests of the unused type or with an index beyond the table give no response
module heartbeat_liveness_monitor (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           start,
   output logic                           busy,
   input  logic [hlm_pkg::REQ_W-1:0]      req_type,
   input  logic [hlm_pkg::ID_W-1:0]       req_session_index,
   input  logic [hlm_pkg::SEQ_W-1:0]      req_activity_seq,
   // response channel
   output logic                           rsp_valid,
   output logic [hlm_pkg::EV_W-1:0]       rsp_event_res,
   output logic [hlm_pkg::ID_W-1:0]       rsp_session_id,
   output logic [hlm_pkg::SEQ_W-1:0]      rsp_ping_seq,
   output logic                           rsp_is_last,
   // register write channel
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [hlm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hlm_pkg::CSR_DATA_W-1:0] csr_wdata
);

`include "heartbeat_liveness_monitor_defines.svh"

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ACC,
      ST_DONE
   } state_type;

   localparam logic [hlm_pkg::ADDR_W-1:0] LAST_IDX = hlm_pkg::ADDR_W'(hlm_pkg::NUM_SESSIONS - 1);

   // control state
   state_type                         state_ff, state_in;
   logic [hlm_pkg::ADDR_W-1:0]        scan_ff, scan_in;
   logic [hlm_pkg::TIME_W-1:0]        time_ff, time_in;
   logic [hlm_pkg::NUM_SESSIONS-1:0]  vld_ff;

   // held request
   hlm_pkg::req_code_type             typ_ff, typ_in;
   logic [hlm_pkg::ADDR_W-1:0]        idx_ff, idx_in;
   logic [hlm_pkg::SEQ_W-1:0]         seq_ff, seq_in;

   // configuration registers
   logic [hlm_pkg::IVL_W-1:0]         ping_interval_ff;
   logic [hlm_pkg::TMO_W-1:0]         pong_timeout_ff;
   logic [hlm_pkg::RETRY_W-1:0]       max_retries_ff;

   // registered response
   logic                              rsp_valid_ff, rsp_valid_in;
   hlm_pkg::event_code_type           rsp_ev_ff, rsp_ev_in;
   logic [hlm_pkg::ID_W-1:0]          rsp_sid_ff, rsp_sid_in;
   logic [hlm_pkg::SEQ_W-1:0]         rsp_seq_ff, rsp_seq_in;
   logic                              rsp_last_ff, rsp_last_in;

   // table memory port
   logic                              ram_we, ram_re;
   logic [hlm_pkg::ADDR_W-1:0]        ram_waddr, ram_raddr;
   logic [hlm_pkg::ENTRY_W-1:0]       ram_rdata;
   hlm_pkg::entry_type                ent_cur, ent_new;

   // per-entry evaluation
   logic [hlm_pkg::ADDR_W-1:0]        proc_idx;
   logic [hlm_pkg::TIME_W-1:0]        waited, idle_for;
   logic                              wait_over, ping_due, chk_ping;
   logic [hlm_pkg::MISS_W-1:0]        miss_inc;
   logic                              in_range;

   hlm_ram #(
      .WIDTH (hlm_pkg::ENTRY_W),
      .DEPTH (hlm_pkg::NUM_SESSIONS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ent_new),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_res  = rsp_ev_ff;
   assign rsp_session_id = rsp_sid_ff;
   assign rsp_ping_seq   = rsp_seq_ff;
   assign rsp_is_last    = rsp_last_ff;

   // index beyond the table gives no response
   assign in_range = (int'(req_session_index) < hlm_pkg::NUM_SESSIONS);

   // the entry being worked on: scan position or the held request index
   assign proc_idx = (state_ff == ST_SCAN) ? scan_ff : idx_ff;

   // an entry never written reads as its reset value
   assign ent_cur = vld_ff[proc_idx] ? hlm_pkg::entry_type'(ram_rdata) : '0;

   // time differences wrap modulo 2^32
   assign waited    = time_ff - ent_cur.ping_sent;
   assign idle_for  = time_ff - ent_cur.last_act;
   assign wait_over = (waited > hlm_pkg::TIME_W'(pong_timeout_ff));
   assign ping_due  = (idle_for >= hlm_pkg::TIME_W'(ping_interval_ff));
   assign miss_inc  = (ent_cur.missed == hlm_pkg::MISS_MAX) ? ent_cur.missed
                                                          : ent_cur.missed + 1'b1;

   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      time_in      = time_ff;
      typ_in       = typ_ff;
      idx_in       = idx_ff;
      seq_in       = seq_ff;
      rsp_valid_in = 1'b0;
      rsp_ev_in    = hlm_pkg::EV_SCAN_DONE;
      rsp_sid_in   = '0;
      rsp_seq_in   = '0;
      rsp_last_in  = 1'b0;
      ram_re       = 1'b0;
      ram_raddr    = '0;
      ram_we       = 1'b0;
      ram_waddr    = proc_idx;
      ent_new      = ent_cur;
      chk_ping     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_type)
                  hlm_pkg::REQ_TICK: begin
                     // advance time, then scan from entry zero
                     time_in   = time_ff + 1'b1;
                     scan_in   = '0;
                     ram_re    = 1'b1;
                     ram_raddr = '0;
                     state_in  = ST_SCAN;
                  end
                  hlm_pkg::REQ_PONG, hlm_pkg::REQ_ACTIVITY: begin
                     if (in_range) begin
                        typ_in    = hlm_pkg::req_code_type'(req_type);
                        idx_in    = hlm_pkg::ADDR_W'(req_session_index);
                        seq_in    = req_activity_seq;
                        ram_re    = 1'b1;
                        ram_raddr = hlm_pkg::ADDR_W'(req_session_index);
                        state_in  = ST_ACC;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // read of the next entry overlaps the update of this one
            if (ent_cur.active) begin
               ram_we   = 1'b1;
               chk_ping = 1'b1;
               if (ent_cur.awaiting) begin
                  if (wait_over) begin
                     ent_new.missed = miss_inc;
                     if (miss_inc > hlm_pkg::MISS_W'(max_retries_ff)) begin
                        // too many misses: drop the session
                        ent_new.active = 1'b0;
                        chk_ping       = 1'b0;
                        rsp_valid_in   = 1'b1;
                        rsp_ev_in      = hlm_pkg::EV_INACTIVE;
                        rsp_sid_in     = hlm_pkg::ID_W'(scan_ff);
                     end else begin
                        ent_new.awaiting = 1'b0;
                     end
                  end else begin
                     chk_ping = 1'b0;
                  end
               end
               if (chk_ping && ping_due) begin
                  ent_new.awaiting  = 1'b1;
                  ent_new.ping_sent = time_ff;
                  rsp_valid_in      = 1'b1;
                  rsp_ev_in         = hlm_pkg::EV_PING;
                  rsp_sid_in        = hlm_pkg::ID_W'(scan_ff);
                  rsp_seq_in        = ent_cur.peer_seq + 1'b1;
               end
            end
            if (scan_ff == LAST_IDX) begin
               state_in = ST_DONE;
            end else begin
               scan_in   = scan_ff + 1'b1;
               ram_re    = 1'b1;
               ram_raddr = scan_ff + 1'b1;
            end
         end

         ST_ACC: begin
            ram_we           = 1'b1;
            ent_new.last_act = time_ff;
            rsp_valid_in     = 1'b1;
            rsp_sid_in       = hlm_pkg::ID_W'(idx_ff);
            rsp_last_in      = 1'b1;
            if (typ_ff == hlm_pkg::REQ_PONG) begin
               // pong revives the session and clears its misses
               ent_new.active   = 1'b1;
               ent_new.awaiting = 1'b0;
               ent_new.missed   = '0;
               rsp_ev_in        = hlm_pkg::EV_PONG;
            end else begin
               // activity opens a closed session fresh
               if (!ent_cur.active) begin
                  ent_new.awaiting = 1'b0;
                  ent_new.missed   = '0;
               end
               ent_new.active   = 1'b1;
               ent_new.peer_seq = seq_ff;
               rsp_ev_in        = hlm_pkg::EV_UPDATED;
            end
            state_in = ST_IDLE;
         end

         ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_ev_in    = hlm_pkg::EV_SCAN_DONE;
            rsp_last_in  = 1'b1;
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         scan_ff          <= '0;
         time_ff          <= '0;
         vld_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
         ping_interval_ff <= hlm_pkg::PING_INTERVAL_RST;
         pong_timeout_ff  <= hlm_pkg::PONG_TIMEOUT_RST;
         max_retries_ff   <= hlm_pkg::MAX_RETRIES_RST;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         time_ff      <= time_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ram_we) begin
            vld_ff[ram_waddr] <= 1'b1;
         end
         // register writes; an index beyond the list is dropped
         if (csr_valid && csr_ready) begin
            case (csr_index)
               hlm_pkg::CSR_PING_INTERVAL: ping_interval_ff <= csr_wdata[hlm_pkg::IVL_W-1:0];
               hlm_pkg::CSR_PONG_TIMEOUT:  pong_timeout_ff  <= csr_wdata[hlm_pkg::TMO_W-1:0];
               hlm_pkg::CSR_MAX_RETRIES:   max_retries_ff   <= csr_wdata[hlm_pkg::RETRY_W-1:0];
               default: begin
               end
            endcase
         end
      end
      // payload, no reset needed
      typ_ff      <= typ_in;
      idx_ff      <= idx_in;
      seq_ff      <= seq_in;
      rsp_ev_ff   <= rsp_ev_in;
      rsp_sid_ff  <= rsp_sid_in;
      rsp_seq_ff  <= rsp_seq_in;
      rsp_last_ff <= rsp_last_in;
   end

   // the scan never reads and writes the same entry in one cycle
   `HLM_ASSERT_NEVER(a_no_rw_same_entry, clock, reset, ram_we && ram_re && (ram_waddr == ram_raddr))
   // nothing is emitted in the cycle after an idle one
   `HLM_ASSERT_NXT(a_idle_no_rsp, clock, reset, state_ff == ST_IDLE, !rsp_valid_ff)
   // an accepted tick always starts a scan
   `HLM_ASSERT_NXT(a_tick_scans, clock, reset, start && !busy && (req_type == hlm_pkg::REQ_TICK), state_ff == ST_SCAN)
   // the scan position stays inside the table
   `HLM_ASSERT_IMP(a_scan_in_table, clock, reset, state_ff == ST_SCAN, int'(scan_ff) < hlm_pkg::NUM_SESSIONS)

endmodule
